[hw/rtl/sfpq_pkg.sv]
// shared types, codes and defaults of the shortest-first priority queue
package sfpq_pkg;

  localparam int unsigned DEPTH_DEF   = 64;
  localparam int unsigned MAX_LEN_DEF = 4096;
  localparam int unsigned HANDLE_W    = 16;

  // operation selector carried in the input tuser
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status carried in the output tuser
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_START_PUSH,
    CMD_START_POP,
    CMD_STEP,
    CMD_INSERT,
    CMD_POP_TAKE,
    CMD_LOAD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic walk_done;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/sfpq_ctrl.sv]
// sequencing state machine of the shortest-first priority queue
module sfpq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_op_i,
  output logic           in_ready_o,
  input  sfpq_pkg::stat_t stat_i,
  output sfpq_pkg::cmd_t  cmd_o
);
  import sfpq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_POP,
    ST_FINISH
  } state_e;

  state_e     state_q;
  logic       ready_q;
  logic [1:0] code_q;

  assign in_ready_o = ready_q;

  always_comb begin
    cmd_o.op   = CMD_NONE;
    cmd_o.code = code_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_PUSH) begin
            cmd_o.op = stat_i.full ? CMD_LATCH : CMD_START_PUSH;
          end else begin
            cmd_o.op = stat_i.empty ? CMD_LATCH : CMD_START_POP;
          end
        end
      end
      ST_WALK: begin
        cmd_o.op = stat_i.walk_done ? CMD_INSERT : CMD_STEP;
      end
      ST_POP: begin
        cmd_o.op = CMD_POP_TAKE;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.op = CMD_LOAD_OUT;
        end
      end
      default: begin
        cmd_o.op = CMD_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
      code_q  <= STATUS_DONE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            ready_q <= 1'b0;
            if (in_op_i == OP_PUSH) begin
              code_q  <= stat_i.full ? STATUS_FULL : STATUS_DONE;
              state_q <= stat_i.full ? ST_FINISH : ST_WALK;
            end else begin
              code_q  <= stat_i.empty ? STATUS_EMPTY : STATUS_DONE;
              state_q <= stat_i.empty ? ST_FINISH : ST_POP;
            end
          end
        end
        ST_WALK: begin
          if (stat_i.walk_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_POP: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (stat_i.out_free) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

[hw/rtl/sfpq_datapath.sv]
// entry store, ring pointers, insertion walk and result register
module sfpq_datapath #(
  parameter int unsigned DEPTH   = sfpq_pkg::DEPTH_DEF,
  parameter int unsigned MAX_LEN = sfpq_pkg::MAX_LEN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sfpq_pkg::cmd_t                    cmd_i,
  output sfpq_pkg::stat_t                   stat_o,
  input  logic                              in_op_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]      in_key_i,
  input  logic [sfpq_pkg::HANDLE_W-1:0]     in_handle_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sfpq_pkg::HANDLE_W-1:0]     out_handle_o,
  output logic [$clog2(MAX_LEN+1)-1:0]      out_length_o,
  output logic [1:0]                        out_status_o,
  output logic [$clog2(DEPTH+1)-1:0]        out_occupancy_o
);
  import sfpq_pkg::*;

  localparam int unsigned KEY_W = $clog2(MAX_LEN + 1);
  localparam int unsigned ENT_W = KEY_W + HANDLE_W;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = PTR_W + 1;

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // entry layout: key in the low bits, handle above
  logic [ENT_W-1:0]    mem_q [DEPTH];
  logic [ENT_W-1:0]    rdata_q;
  logic [PTR_W-1:0]    rd_addr;
  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  logic [ENT_W-1:0]    wr_data;

  logic [PTR_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [PTR_W-1:0]    fill_q, fill_d;   // slot waiting to be filled
  logic [PTR_W-1:0]    rd_q, rd_d;       // slot just below the fill slot
  logic [SUM_W-1:0]    tail_sum;
  logic [PTR_W-1:0]    tail;

  logic                op_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [ENT_W-1:0]    res_q;
  logic                out_valid_q;
  logic                item_latch;

  assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
  assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                : PTR_W'(tail_sum);

  assign item_latch = (cmd_i.op == CMD_LATCH) || (cmd_i.op == CMD_START_PUSH) ||
                      (cmd_i.op == CMD_START_POP);

  always_comb begin
    rd_addr = rd_q;
    wr_en   = 1'b0;
    wr_addr = fill_q;
    wr_data = {handle_q, key_q};
    head_d  = head_q;
    count_d = count_q;
    fill_d  = fill_q;
    rd_d    = rd_q;
    case (cmd_i.op)
      CMD_START_PUSH: begin
        fill_d  = tail;
        rd_d    = ptr_dec(tail);
        rd_addr = ptr_dec(tail);
      end
      CMD_START_POP: begin
        rd_addr = head_q;
      end
      CMD_STEP: begin
        // move the larger entry up one slot and look one further down
        wr_en   = 1'b1;
        wr_data = rdata_q;
        fill_d  = rd_q;
        rd_d    = ptr_dec(rd_q);
        rd_addr = ptr_dec(rd_q);
      end
      CMD_INSERT: begin
        wr_en   = 1'b1;
        count_d = count_q + 1'b1;
      end
      CMD_POP_TAKE: begin
        head_d  = ptr_inc(head_q);
        count_d = count_q - 1'b1;
      end
      default: begin
        rd_addr = rd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      fill_q      <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      fill_q  <= fill_d;
      rd_q    <= rd_d;
      if (cmd_i.op == CMD_LOAD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_latch) begin
      op_q     <= in_op_i;
      handle_q <= in_handle_i;
      key_q    <= (in_key_i > KEY_W'(MAX_LEN)) ? KEY_W'(MAX_LEN) : in_key_i;
    end
    if (cmd_i.op == CMD_POP_TAKE) begin
      res_q <= rdata_q;
    end
    if (cmd_i.op == CMD_LOAD_OUT) begin
      out_status_o    <= cmd_i.code;
      out_occupancy_o <= count_q;
      if ((op_q == OP_POP) && (cmd_i.code == STATUS_DONE)) begin
        out_handle_o <= res_q[ENT_W-1:KEY_W];
        out_length_o <= res_q[KEY_W-1:0];
      end else begin
        out_handle_o <= '0;
        out_length_o <= '0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.full      = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.walk_done = (fill_q == head_q) || !(rdata_q[KEY_W-1:0] > key_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

[hw/rtl/shortest_first_priority_queue.sv]
// top level: shortest-first queue of message handles sorted by length
// a push steps the walk once per stored entry with a larger key; a refused item skips the walk
// throughput: one item at a time; the insertion walk reads one entry and writes one
//   entry of the store per cycle
// reset: count, ring head, state machine and output valid clear; the entry store
//   is not cleared and needs no clearing pass
module shortest_first_priority_queue #(
  parameter int unsigned DEPTH   = sfpq_pkg::DEPTH_DEF,
  parameter int unsigned MAX_LEN = sfpq_pkg::MAX_LEN_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // input words: tdata = msg_length, msg_handle; tuser = operation
  input  logic                                                           s_axis_tvalid,
  output logic                                                           s_axis_tready,
  input  logic [(($clog2(MAX_LEN+1)+sfpq_pkg::HANDLE_W+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                                           s_axis_tuser,
  // result words: tdata = out_handle, out_length, occupancy; tuser = status
  output logic                                                           m_axis_tvalid,
  input  logic                                                           m_axis_tready,
  output logic [((sfpq_pkg::HANDLE_W+$clog2(MAX_LEN+1)+$clog2(DEPTH+1)+7)/8)*8-1:0]
                                                                         m_axis_tdata,
  output logic [1:0]                                                     m_axis_tuser
);
  import sfpq_pkg::*;

  localparam int unsigned KEY_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned OUT_DW = ((HANDLE_W + KEY_W + CNT_W + 7) / 8) * 8;

  cmd_t                cmd;
  stat_t               stat;
  logic [HANDLE_W-1:0] out_handle;
  logic [KEY_W-1:0]    out_length;
  logic [CNT_W-1:0]    out_occupancy;

  // controller: accepts a word only in its idle state, then steps the datapath
  sfpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: ring-organized sorted store, the walk that opens a slot for a
  // push, and the result register that holds a word until the sink takes it
  sfpq_datapath #(
    .DEPTH   (DEPTH),
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_op_i         (s_axis_tuser),
    .in_key_i        (s_axis_tdata[KEY_W-1:0]),
    .in_handle_i     (s_axis_tdata[KEY_W+HANDLE_W-1:KEY_W]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_handle_o    (out_handle),
    .out_length_o    (out_length),
    .out_status_o    (m_axis_tuser),
    .out_occupancy_o (out_occupancy)
  );

  // pack result fields from the low bit up, zero padded to whole bytes
  assign m_axis_tdata = OUT_DW'({out_occupancy, out_length, out_handle});

endmodule

[hw/rtl/sfpq_checker.sv]
// port-level checks of the shortest-first priority queue, bound to the top level
module sfpq_checker #(
  parameter int unsigned DEPTH   = sfpq_pkg::DEPTH_DEF,
  parameter int unsigned MAX_LEN = sfpq_pkg::MAX_LEN_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  // tdata = out_handle, out_length, occupancy
  input logic [((sfpq_pkg::HANDLE_W+$clog2(MAX_LEN+1)+$clog2(DEPTH+1)+7)/8)*8-1:0]
              m_axis_tdata,
  // tuser = status
  input logic [1:0] m_axis_tuser
);
  import sfpq_pkg::*;

  localparam int unsigned KEY_W = $clog2(MAX_LEN + 1);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OCC_L = HANDLE_W + KEY_W;

  // one word in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a word is in flight");

  // a refused push only happens with the store full
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STATUS_FULL)) |->
      (m_axis_tdata[OCC_L+CNT_W-1:OCC_L] == CNT_W'(DEPTH)))
    else $error("full status with store not full");

  // a refused pop shows an empty store and a zero payload
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STATUS_EMPTY)) |->
      (m_axis_tdata[OCC_L+CNT_W-1:0] == '0))
    else $error("empty status with nonzero payload or occupancy");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result word changed while stalled");

endmodule

bind shortest_first_priority_queue sfpq_checker #(
  .DEPTH   (DEPTH),
  .MAX_LEN (MAX_LEN)
) u_sfpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
